// ===== sv/tkprc_pkg.sv =====
// -----------------------------------------------------------------------------
// tkprc_pkg
// shared types, widths, key layout and register codes for the touch key block
// -----------------------------------------------------------------------------
package tkprc_pkg;

	localparam int KEYS           = 9;
	localparam int TOUCHES        = 4;
	localparam int COORD_W        = 9;
	localparam int KEY_SIZE_W     = 7;
	localparam int REG_W          = 8;
	localparam int CFG_INDEX_W    = 2;
	localparam int COUNT_BITS_DEF = 8;
	localparam int COUNT_WRAP     = 16;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 48;

	localparam logic [KEY_SIZE_W-1:0] KEY_SIZE_RST     = 7'd40;
	localparam logic [REG_W-1:0]      REPEAT_DELAY_RST = 8'd15;
	localparam logic [REG_W-1:0]      CLICK_LIMIT_RST  = 8'd8;

	// key order: up, down, left, right, a, b, x, y, start
	localparam logic [COORD_W-1:0] CORNER_X [KEYS] = '{
		9'd50, 9'd50, 9'd10, 9'd90, 9'd270, 9'd230, 9'd230, 9'd190, 9'd140
	};
	localparam logic [COORD_W-1:0] CORNER_Y [KEYS] = '{
		9'd300, 9'd380, 9'd340, 9'd340, 9'd340, 9'd380, 9'd300, 9'd340, 9'd440
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_SIZE     = 2'd0,
		REG_REPEAT_DELAY = 2'd1,
		REG_CLICK_LIMIT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} touch_t;

endpackage

// ===== sv/tkprc_hit.sv =====
// -----------------------------------------------------------------------------
// tkprc_hit
// hit test of every touch point against the fixed key squares
// -----------------------------------------------------------------------------
module tkprc_hit (
	input  logic [tkprc_pkg::TOUCHES-1:0]    touch_valid,
	input  tkprc_pkg::touch_t                touch [tkprc_pkg::TOUCHES],
	input  logic [tkprc_pkg::KEY_SIZE_W-1:0] key_size,
	output logic [tkprc_pkg::KEYS-1:0]       hit
);
	import tkprc_pkg::*;

	always_comb begin
		logic                 found;
		logic [COORD_W:0]     px;
		logic [COORD_W:0]     py;
		logic [COORD_W:0]     lo_x;
		logic [COORD_W:0]     lo_y;
		hit   = '0;
		found = 1'b0;
		px    = '0;
		py    = '0;
		lo_x  = '0;
		lo_y  = '0;
		for (int t = 0; t < TOUCHES; t++) begin
			px    = {1'b0, touch[t].x};
			py    = {1'b0, touch[t].y};
			found = 1'b0;
			// a touch only lands on the first key it falls inside
			for (int k = 0; k < KEYS; k++) begin
				lo_x = {1'b0, CORNER_X[k]};
				lo_y = {1'b0, CORNER_Y[k]};
				if (touch_valid[t] && !found &&
				    px >= lo_x && px <= lo_x + (COORD_W+1)'(key_size) &&
				    py >= lo_y && py <= lo_y + (COORD_W+1)'(key_size)) begin
					hit[k] = 1'b1;
					found  = 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/touch_key_press_repeat_click.sv =====
// -----------------------------------------------------------------------------
// touch_key_press_repeat_click
// touch and button key tracker with press, release, click and auto-repeat
// -----------------------------------------------------------------------------
// one input item per frame tick on s_*: up to four touch points plus the
// physical button mask. one result item per input on m_*: held, pressed,
// released, clicked and repeat masks over nine keys.
// path: an item passes through the input register, then the result register,
// so the result on m_* is registered. throughput: one item per cycle while
// m_tready is high; per-key counters and the held mask are updated as an
// item moves from the input register into the result register, so
// consecutive items see each other's state.
// cfg_* writes key_size, repeat_delay and click_limit; cfg_ready is always
// high. write only while no item is in flight.
// reset: all keys released, counters zero, registers at key_size 40,
// repeat_delay 15, click_limit 8.
// when m_tready is low the result register holds; the input register still
// takes one more item, then s_tready drops until the result is taken.
// -----------------------------------------------------------------------------
module touch_key_press_repeat_click #(
	parameter int COUNT_BITS = tkprc_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tkprc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tkprc_pkg::REG_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// touch_valid[3:0], touch0_x, touch0_y, touch1_x, touch1_y, touch2_x,
	// touch2_y, touch3_x, touch3_y (9 bits each), held_buttons[8:0], zero pad
	input  logic [tkprc_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// on_keys, pressed_keys, released_keys, clicked_keys, repeat_keys
	// (9 bits each), zero pad
	output logic [tkprc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import tkprc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
	localparam int IN_BITS = TOUCHES + 2 * TOUCHES * COORD_W + KEYS;

	// configuration registers
	logic [KEY_SIZE_W-1:0] key_size_q;
	logic [REG_W-1:0]      repeat_delay_q;
	logic [REG_W-1:0]      click_limit_q;

	// input register
	logic                  valid_s1;
	logic [TOUCHES-1:0]    tvalid_s1;
	touch_t                touch_s1 [TOUCHES];
	logic [KEYS-1:0]       buttons_s1;

	// result register
	logic                  valid_s2;
	logic [KEYS-1:0]       on_s2;
	logic [KEYS-1:0]       pressed_s2;
	logic [KEYS-1:0]       released_s2;
	logic [KEYS-1:0]       clicked_s2;
	logic [KEYS-1:0]       repeat_s2;

	// key state
	logic [KEYS-1:0]       prev_on_q;
	logic [COUNT_BITS-1:0] hold_q [KEYS];
	logic [COUNT_BITS-1:0] hold_d [KEYS];

	logic                  advance;
	logic [KEYS-1:0]       hit;
	logic [KEYS-1:0]       on_d;
	logic [KEYS-1:0]       pressed_d;
	logic [KEYS-1:0]       released_d;
	logic [KEYS-1:0]       clicked_d;
	logic [KEYS-1:0]       repeat_d;
	logic [KEYS-1:0]       count_nz;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q     <= KEY_SIZE_RST;
			repeat_delay_q <= REPEAT_DELAY_RST;
			click_limit_q  <= CLICK_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_SIZE:     key_size_q     <= cfg_data[KEY_SIZE_W-1:0];
				REG_REPEAT_DELAY: repeat_delay_q <= cfg_data;
				REG_CLICK_LIMIT:  click_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tvalid_s1 <= s_tdata[TOUCHES-1:0];
			for (int t = 0; t < TOUCHES; t++) begin
				touch_s1[t].x <= s_tdata[TOUCHES + 2*t*COORD_W +: COORD_W];
				touch_s1[t].y <= s_tdata[TOUCHES + (2*t+1)*COORD_W +: COORD_W];
			end
			buttons_s1 <= s_tdata[IN_BITS-KEYS +: KEYS];
		end
	end

	tkprc_hit u_hit (
		.touch_valid (tvalid_s1),
		.touch       (touch_s1),
		.key_size    (key_size_q),
		.hit         (hit)
	);

	always_comb begin
		logic [COUNT_BITS-1:0] cnt;
		cnt        = '0;
		on_d       = hit | buttons_s1;
		pressed_d  = on_d & ~prev_on_q;
		released_d = ~on_d & prev_on_q;
		clicked_d  = '0;
		repeat_d   = pressed_d;
		for (int k = 0; k < KEYS; k++) begin
			cnt = hold_q[k];
			if (on_d[k]) begin
				if (CMP_W'(cnt) > CMP_W'(repeat_delay_q) && cnt[1:0] == 2'b00) begin
					repeat_d[k] = 1'b1;
				end
				// saturating wrap keeps the four-frame cadence
				hold_d[k] = (&cnt) ? COUNT_BITS'(COUNT_WRAP) : cnt + 1'b1;
			end else begin
				if (prev_on_q[k] && CMP_W'(cnt) <= CMP_W'(click_limit_q)) begin
					clicked_d[k] = 1'b1;
				end
				hold_d[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_on_q <= '0;
			for (int k = 0; k < KEYS; k++) begin
				hold_q[k] <= '0;
			end
		end else if (advance) begin
			prev_on_q <= on_d;
			for (int k = 0; k < KEYS; k++) begin
				hold_q[k] <= hold_d[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			on_s2       <= on_d;
			pressed_s2  <= pressed_d;
			released_s2 <= released_d;
			clicked_s2  <= clicked_d;
			repeat_s2   <= repeat_d;
		end
	end

	assign m_tdata = {
		(OUT_TDATA_W - 5*KEYS)'(0),
		repeat_s2, clicked_s2, released_s2, pressed_s2, on_s2
	};

	always_comb begin
		for (int k = 0; k < KEYS; k++) begin
			count_nz[k] = |hold_q[k];
		end
	end

	// a key that was not held last frame has its counter cleared
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(count_nz & ~prev_on_q) == '0)
		else $error("hold counter running for a released key");

	a_click_sub: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (clicked_s2 & ~released_s2) == '0)
		else $error("click without release");

	a_press_rep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (pressed_s2 & ~repeat_s2) == '0 && (pressed_s2 & released_s2) == '0)
		else $error("press not flagged as repeat, or pressed and released together");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(prev_on_q))
		else $error("key state moved without an item");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && on_s2 == prev_on_q)
		else $error("result register out of step with key state");

endmodule
